>>> design/aff2d_pkg.sv
// ----------------------------------------------------------------------------
// 2D affine transform package
// Shared item types, fixed field widths and constants for the sprite
// transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aff2d_pkg;

	localparam int FIELD_W = 32;
	localparam int DEG_W = 25;
	localparam int DEG_PER_TURN = 360;
	// One eighth of a turn in whole degrees; the turn is 8 * 45 * 2^FRAC_BITS.
	localparam int OCTANT_DIV = 45;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] scale_x;
		logic signed [FIELD_W-1:0] scale_y;
		logic signed [FIELD_W-1:0] origin_x;
		logic signed [FIELD_W-1:0] origin_y;
		logic signed [FIELD_W-1:0] rotation_deg;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] m_a;
		logic signed [FIELD_W-1:0] m_b;
		logic signed [FIELD_W-1:0] m_tx;
		logic signed [FIELD_W-1:0] m_c;
		logic signed [FIELD_W-1:0] m_d;
		logic signed [FIELD_W-1:0] m_ty;
		logic [DEG_W-1:0] wrapped_deg;
	} result_t;

	// Geometry that rides along the angle and sine stages untouched.
	typedef struct packed {
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] scale_x;
		logic signed [FIELD_W-1:0] scale_y;
		logic signed [FIELD_W-1:0] origin_x;
		logic signed [FIELD_W-1:0] origin_y;
	} geo_t;

endpackage

`default_nettype wire

>>> design/affine_2d_local_transform.sv
// ----------------------------------------------------------------------------
// 2D affine local transform
// Turns one sprite's position, scale, origin and rotation into the six
// saturated terms of its affine matrix plus the wrapped angle.
// ----------------------------------------------------------------------------
// Pipeline: a beat accepted by the block shows on result, with done high, after
// it has passed thirteen register stages (s1 to s13).
// Throughput: one beat per clock; busy stays low, so start may be high in
// every cycle. The pipeline never stalls since results cannot be held off.
// Reset: arst_n clears the stage valid bits; data registers are not reset.
`default_nettype none

module affine_2d_local_transform #(
	parameter int FRAC_BITS = 16,
	parameter int SINE_TABLE_ENTRIES = 256,
	parameter int SINE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  aff2d_pkg::in_item_t item,
	output logic                done,
	output aff2d_pkg::result_t  result
);
	import aff2d_pkg::*;

	localparam int W_W = FRAC_BITS + 9;
	localparam int A_W = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int SC_W = SINE_BITS + 2;
	localparam int ACCEPT_TO_DONE = 13;

	logic a_valid;
	geo_t a_geo;
	logic [W_W-1:0] a_wrapped;
	logic [1:0] a_quad;
	logic [A_W-1:0] a_addr_r;
	logic [A_W-1:0] a_addr_n;

	logic s_valid;
	geo_t s_geo;
	logic [W_W-1:0] s_wrapped;
	logic signed [SC_W-1:0] s_sin;
	logic signed [SC_W-1:0] s_cos;

	logic accept;

	assign busy = 1'b0;
	assign accept = start && !busy;

	aff2d_angle #(
		.FRAC_BITS(FRAC_BITS),
		.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
	) u_angle (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.in_item(item),
		.out_valid(a_valid),
		.out_geo(a_geo),
		.out_wrapped(a_wrapped),
		.out_quad(a_quad),
		.out_addr_r(a_addr_r),
		.out_addr_n(a_addr_n)
	);

	aff2d_sine #(
		.FRAC_BITS(FRAC_BITS),
		.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
		.SINE_BITS(SINE_BITS)
	) u_sine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(a_valid),
		.in_geo(a_geo),
		.in_wrapped(a_wrapped),
		.in_quad(a_quad),
		.in_addr_r(a_addr_r),
		.in_addr_n(a_addr_n),
		.out_valid(s_valid),
		.out_geo(s_geo),
		.out_wrapped(s_wrapped),
		.out_sin(s_sin),
		.out_cos(s_cos)
	);

	aff2d_matrix #(
		.FRAC_BITS(FRAC_BITS),
		.SINE_BITS(SINE_BITS)
	) u_matrix (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_valid),
		.in_geo(s_geo),
		.in_wrapped(s_wrapped),
		.in_sin(s_sin),
		.in_cos(s_cos),
		.out_valid(done),
		.out_result(result)
	);

	a_beat_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##ACCEPT_TO_DONE done)
		else $error("accepted beat did not produce a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, ACCEPT_TO_DONE))
		else $error("result without a matching accepted beat");

endmodule

`default_nettype wire

>>> design/aff2d_angle.sv
// ----------------------------------------------------------------------------
// Angle wrap and table index
// Wraps the rotation into one turn and quantizes it to a quadrant and a
// quarter-wave table offset (pipeline stages s1 to s6).
// ----------------------------------------------------------------------------
`default_nettype none

module aff2d_angle #(
	parameter int FRAC_BITS = 16,
	parameter int SINE_TABLE_ENTRIES = 256,
	localparam int W_W = FRAC_BITS + 9,
	localparam int A_W = $clog2(SINE_TABLE_ENTRIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  aff2d_pkg::in_item_t in_item,
	output logic                out_valid,
	output aff2d_pkg::geo_t     out_geo,
	output logic [W_W-1:0]      out_wrapped,
	output logic [1:0]          out_quad,
	output logic [A_W-1:0]      out_addr_r,
	output logic [A_W-1:0]      out_addr_n
);
	import aff2d_pkg::*;

	localparam int N = SINE_TABLE_ENTRIES;
	localparam int LO_W = FRAC_BITS + 3;
	localparam int H2_W = FIELD_W - LO_W;
	localparam int U_W = H2_W + 5;
	localparam longint unsigned U_OFFS = 64'(OCTANT_DIV) << (H2_W - 1);
	localparam int R1_W = U_W - 5;
	localparam longint unsigned R1 = (64'd1 << U_W) / OCTANT_DIV;
	localparam longint unsigned TURN = 64'(DEG_PER_TURN) << FRAC_BITS;
	localparam int MULT = 8 * N;
	localparam int NUM_W = W_W + $clog2(MULT + 1) + 1;
	localparam int V_W = $clog2(180 * N + 24);
	localparam int R2_W = V_W - 5;
	localparam longint unsigned R2 = (64'd1 << V_W) / OCTANT_DIV;
	localparam int I_W = $clog2(4 * N + 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6;

	logic [U_W-1:0] u_s1, u_s2;
	logic [LO_W-1:0] lo_s1, lo_s2;
	logic [U_W+R1_W-1:0] prod1_s2;
	logic [W_W-1:0] wrapped_s3, wrapped_s4, wrapped_s5, wrapped_s6;
	logic [V_W-1:0] v_deg_s4, v_deg_s5;
	logic [V_W+R2_W-1:0] prod2_s5;
	logic [1:0] quad_s6;
	logic [A_W-1:0] addr_r_s6, addr_n_s6;

	logic [H2_W-1:0] h2;
	logic [U_W-1:0] u_next;
	logic [R1_W-1:0] q1;
	logic [6:0] rem1;
	logic [5:0] m45;
	logic [NUM_W-1:0] num;
	logic [I_W-1:0] q2;
	logic [6:0] rem2;
	logic [I_W-1:0] idx_raw, idx;
	logic [I_W-1:0] rq;
	logic [1:0] quad;

	// Whole multiples of eight degrees, biased by a multiple of 45 so the remainder
	// below works on an unsigned value and still gives the floor modulo.
	assign h2 = in_item.rotation_deg[FIELD_W-1:LO_W];
	assign u_next = U_W'({{(U_W - H2_W){h2[H2_W-1]}}, h2}) + U_W'(U_OFFS);

	// Reciprocal quotient may be low by one; one compare-subtract fixes it.
	assign q1 = R1_W'(prod1_s2 >> U_W);
	assign rem1 = 7'(u_s2 - U_W'(q1) * U_W'(OCTANT_DIV));
	assign m45 = (rem1 >= 7'(OCTANT_DIV)) ? 6'(rem1 - 7'(OCTANT_DIV)) : 6'(rem1);

	// Round half up of wrapped * 4N / turn, done as a shift and a divide by 45.
	assign num = NUM_W'(wrapped_s3) * NUM_W'(MULT) + NUM_W'(TURN);

	assign q2 = I_W'(prod2_s5 >> V_W);
	assign rem2 = 7'(v_deg_s5 - V_W'(q2) * V_W'(OCTANT_DIV));
	assign idx_raw = (rem2 >= 7'(OCTANT_DIV)) ? q2 + I_W'(1) : q2;
	assign idx = (idx_raw == I_W'(4 * N)) ? '0 : idx_raw;

	always_comb begin
		priority if (idx >= I_W'(3 * N)) begin
			quad = QUAD_3;
			rq = idx - I_W'(3 * N);
		end else if (idx >= I_W'(2 * N)) begin
			quad = QUAD_2;
			rq = idx - I_W'(2 * N);
		end else if (idx >= I_W'(N)) begin
			quad = QUAD_1;
			rq = idx - I_W'(N);
		end else begin
			quad = QUAD_0;
			rq = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		geo_s1.pos_x <= in_item.pos_x;
		geo_s1.pos_y <= in_item.pos_y;
		geo_s1.scale_x <= in_item.scale_x;
		geo_s1.scale_y <= in_item.scale_y;
		geo_s1.origin_x <= in_item.origin_x;
		geo_s1.origin_y <= in_item.origin_y;
		u_s1 <= u_next;
		lo_s1 <= in_item.rotation_deg[LO_W-1:0];

		geo_s2 <= geo_s1;
		u_s2 <= u_s1;
		lo_s2 <= lo_s1;
		prod1_s2 <= (U_W + R1_W)'(u_s1) * (U_W + R1_W)'(R1);

		geo_s3 <= geo_s2;
		wrapped_s3 <= {m45, lo_s2};

		geo_s4 <= geo_s3;
		wrapped_s4 <= wrapped_s3;
		v_deg_s4 <= V_W'(num >> (FRAC_BITS + 4));

		geo_s5 <= geo_s4;
		wrapped_s5 <= wrapped_s4;
		v_deg_s5 <= v_deg_s4;
		prod2_s5 <= (V_W + R2_W)'(v_deg_s4) * (V_W + R2_W)'(R2);

		geo_s6 <= geo_s5;
		wrapped_s6 <= wrapped_s5;
		quad_s6 <= quad;
		addr_r_s6 <= A_W'(rq);
		addr_n_s6 <= A_W'(N) - A_W'(rq);
	end

	assign out_valid = v_s6;
	assign out_geo = geo_s6;
	assign out_wrapped = wrapped_s6;
	assign out_quad = quad_s6;
	assign out_addr_r = addr_r_s6;
	assign out_addr_n = addr_n_s6;

	a_wrap_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (64'(wrapped_s3) < TURN))
		else $error("wrapped angle left the turn");

	a_recip_close: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem1 < 7'(2 * OCTANT_DIV)))
		else $error("reciprocal quotient off by more than one");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (addr_r_s6 < A_W'(N)))
		else $error("quadrant offset out of range");

endmodule

`default_nettype wire

>>> design/aff2d_sine.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine lookup
// Reads the quarter-wave table at the offset and its complement and applies
// the quadrant signs for the negated angle (pipeline stages s7 and s8).
// ----------------------------------------------------------------------------
`default_nettype none

module aff2d_sine #(
	parameter int FRAC_BITS = 16,
	parameter int SINE_TABLE_ENTRIES = 256,
	parameter int SINE_BITS = 16,
	localparam int W_W = FRAC_BITS + 9,
	localparam int A_W = $clog2(SINE_TABLE_ENTRIES + 1),
	localparam int SC_W = SINE_BITS + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  aff2d_pkg::geo_t        in_geo,
	input  logic [W_W-1:0]         in_wrapped,
	input  logic [1:0]             in_quad,
	input  logic [A_W-1:0]         in_addr_r,
	input  logic [A_W-1:0]         in_addr_n,
	output logic                   out_valid,
	output aff2d_pkg::geo_t        out_geo,
	output logic [W_W-1:0]         out_wrapped,
	output logic signed [SC_W-1:0] out_sin,
	output logic signed [SC_W-1:0] out_cos
);
	import aff2d_pkg::*;

	localparam int N = SINE_TABLE_ENTRIES;
	localparam int T_W = SINE_BITS + 1;
	localparam longint unsigned TWO_N = 64'(2 * N);
	localparam longint unsigned TAYLOR_DIV [1:10] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

	typedef logic [T_W-1:0] tab_t [0:N];

	// Eleven-term Taylor series in Q30, rounded half up to SINE_BITS and clamped
	// to one. Evaluated once at elaboration.
	function automatic tab_t build_table();
		tab_t t;
		longint unsigned x;
		longint unsigned term;
		longint sum;
		longint e;
		for (int k = 0; k <= N; k++) begin
			x = (64'(k) * 64'd2 * HALF_PI_Q30 + 64'(N)) / TWO_N;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 10; n++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / TAYLOR_DIV[n];
				if (n[0]) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			e = (sum * (longint'(1) << SINE_BITS) + (longint'(1) << 29)) >>> 30;
			if (e > (longint'(1) << SINE_BITS)) begin
				e = longint'(1) << SINE_BITS;
			end
			t[k] = T_W'(e);
		end
		return t;
	endfunction

	localparam tab_t SINE_TAB = build_table();

	logic v_s7, v_s8;
	geo_t geo_s7, geo_s8;
	logic [W_W-1:0] wrapped_s7, wrapped_s8;
	logic [1:0] quad_s7;
	logic [T_W-1:0] t_r_s7, t_n_s7;
	logic signed [SC_W-1:0] sin_s8, cos_s8;

	logic signed [SC_W-1:0] tr, tn;
	logic signed [SC_W-1:0] sin_next, cos_next;

	assign tr = SC_W'(t_r_s7);
	assign tn = SC_W'(t_n_s7);

	// Sine is taken of the negated angle, so its sign is flipped here too.
	always_comb begin
		unique case (quad_s7)
			QUAD_0: begin
				sin_next = -tr;
				cos_next = tn;
			end
			QUAD_1: begin
				sin_next = -tn;
				cos_next = -tr;
			end
			QUAD_2: begin
				sin_next = tr;
				cos_next = -tn;
			end
			QUAD_3: begin
				sin_next = tn;
				cos_next = tr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= in_valid;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		geo_s7 <= in_geo;
		wrapped_s7 <= in_wrapped;
		quad_s7 <= in_quad;
		t_r_s7 <= SINE_TAB[in_addr_r];
		t_n_s7 <= SINE_TAB[in_addr_n];

		geo_s8 <= geo_s7;
		wrapped_s8 <= wrapped_s7;
		sin_s8 <= sin_next;
		cos_s8 <= cos_next;
	end

	assign out_valid = v_s8;
	assign out_geo = geo_s8;
	assign out_wrapped = wrapped_s8;
	assign out_sin = sin_s8;
	assign out_cos = cos_s8;

endmodule

`default_nettype wire

>>> design/aff2d_matrix.sv
// ----------------------------------------------------------------------------
// Affine matrix terms
// Scales sine and cosine, folds in the origin and position, and saturates
// the six terms to Q16.16 (pipeline stages s9 to s13).
// ----------------------------------------------------------------------------
`default_nettype none

module aff2d_matrix #(
	parameter int FRAC_BITS = 16,
	parameter int SINE_BITS = 16,
	localparam int W_W = FRAC_BITS + 9,
	localparam int SC_W = SINE_BITS + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  aff2d_pkg::geo_t        in_geo,
	input  logic [W_W-1:0]         in_wrapped,
	input  logic signed [SC_W-1:0] in_sin,
	input  logic signed [SC_W-1:0] in_cos,
	output logic                   out_valid,
	output aff2d_pkg::result_t     out_result
);
	import aff2d_pkg::*;

	localparam int P1_W = FIELD_W + SC_W;
	// A scaled term reaches 2^31 at most, which needs one bit over a field.
	localparam int TERM_W = FIELD_W + 1;
	localparam int P2_W = FIELD_W + TERM_W;
	localparam int R_W = P2_W - FRAC_BITS;
	localparam int S_W = R_W + 2;
	localparam logic signed [P1_W-1:0] RND1 = P1_W'(64'sd1 <<< (SINE_BITS - 1));
	localparam logic signed [P2_W-1:0] RND2 = P2_W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [63:0] FIELD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] FIELD_MIN = -64'sd2147483648;

	function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [63:0] v);
		logic signed [FIELD_W-1:0] r;
		if (v > FIELD_MAX) begin
			r = FIELD_W'(FIELD_MAX);
		end else if (v < FIELD_MIN) begin
			r = FIELD_W'(FIELD_MIN);
		end else begin
			r = FIELD_W'(v);
		end
		return r;
	endfunction

	logic v_s9, v_s10, v_s11, v_s12, v_s13;

	logic signed [FIELD_W-1:0] px_s9, px_s10, px_s11, px_s12;
	logic signed [FIELD_W-1:0] py_s9, py_s10, py_s11, py_s12;
	logic signed [FIELD_W-1:0] ox_s9, ox_s10;
	logic signed [FIELD_W-1:0] oy_s9, oy_s10;
	logic [W_W-1:0] wrapped_s9, wrapped_s10, wrapped_s11, wrapped_s12;

	logic signed [P1_W-1:0] p_xc_s9, p_yc_s9, p_xs_s9, p_ys_s9;
	logic signed [TERM_W-1:0] sxc_s10, syc_s10, sxs_s10, sys_s10;
	logic signed [P2_W-1:0] p_oxc_s11, p_oys_s11, p_oxs_s11, p_oyc_s11;
	logic signed [FIELD_W-1:0] ma_s11, mb_s11, mc_s11, md_s11;
	logic signed [R_W-1:0] r_oxc_s12, r_oys_s12, r_oxs_s12, r_oyc_s12;
	logic signed [FIELD_W-1:0] ma_s12, mb_s12, mc_s12, md_s12;
	result_t res_s13;

	logic signed [TERM_W:0] neg_sxs;
	logic signed [S_W-1:0] tx_sum, ty_sum;

	assign neg_sxs = -((TERM_W + 1)'(sxs_s10));

	assign tx_sum = -S_W'(r_oxc_s12) - S_W'(r_oys_s12) + S_W'(px_s12);
	assign ty_sum = S_W'(r_oxs_s12) - S_W'(r_oyc_s12) + S_W'(py_s12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			v_s9 <= in_valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		px_s9 <= in_geo.pos_x;
		py_s9 <= in_geo.pos_y;
		ox_s9 <= in_geo.origin_x;
		oy_s9 <= in_geo.origin_y;
		wrapped_s9 <= in_wrapped;
		p_xc_s9 <= P1_W'($signed(in_geo.scale_x)) * P1_W'(in_cos);
		p_yc_s9 <= P1_W'($signed(in_geo.scale_y)) * P1_W'(in_cos);
		p_xs_s9 <= P1_W'($signed(in_geo.scale_x)) * P1_W'(in_sin);
		p_ys_s9 <= P1_W'($signed(in_geo.scale_y)) * P1_W'(in_sin);

		px_s10 <= px_s9;
		py_s10 <= py_s9;
		ox_s10 <= ox_s9;
		oy_s10 <= oy_s9;
		wrapped_s10 <= wrapped_s9;
		sxc_s10 <= TERM_W'((p_xc_s9 + RND1) >>> SINE_BITS);
		syc_s10 <= TERM_W'((p_yc_s9 + RND1) >>> SINE_BITS);
		sxs_s10 <= TERM_W'((p_xs_s9 + RND1) >>> SINE_BITS);
		sys_s10 <= TERM_W'((p_ys_s9 + RND1) >>> SINE_BITS);

		px_s11 <= px_s10;
		py_s11 <= py_s10;
		wrapped_s11 <= wrapped_s10;
		p_oxc_s11 <= P2_W'(ox_s10) * P2_W'(sxc_s10);
		p_oys_s11 <= P2_W'(oy_s10) * P2_W'(sys_s10);
		p_oxs_s11 <= P2_W'(ox_s10) * P2_W'(sxs_s10);
		p_oyc_s11 <= P2_W'(oy_s10) * P2_W'(syc_s10);
		ma_s11 <= sat_field(64'(sxc_s10));
		mb_s11 <= sat_field(64'(sys_s10));
		mc_s11 <= sat_field(64'(neg_sxs));
		md_s11 <= sat_field(64'(syc_s10));

		px_s12 <= px_s11;
		py_s12 <= py_s11;
		wrapped_s12 <= wrapped_s11;
		r_oxc_s12 <= R_W'((p_oxc_s11 + RND2) >>> FRAC_BITS);
		r_oys_s12 <= R_W'((p_oys_s11 + RND2) >>> FRAC_BITS);
		r_oxs_s12 <= R_W'((p_oxs_s11 + RND2) >>> FRAC_BITS);
		r_oyc_s12 <= R_W'((p_oyc_s11 + RND2) >>> FRAC_BITS);
		ma_s12 <= ma_s11;
		mb_s12 <= mb_s11;
		mc_s12 <= mc_s11;
		md_s12 <= md_s11;

		res_s13.m_a <= ma_s12;
		res_s13.m_b <= mb_s12;
		res_s13.m_tx <= sat_field(64'(tx_sum));
		res_s13.m_c <= mc_s12;
		res_s13.m_d <= md_s12;
		res_s13.m_ty <= sat_field(64'(ty_sum));
		res_s13.wrapped_deg <= DEG_W'(wrapped_s12);
	end

	assign out_valid = v_s13;
	assign out_result = res_s13;

endmodule

`default_nettype wire
